[rtl/core/ptf_pkg.sv]
// Shared types and constants for the quadrupole factor pipeline.
`timescale 1ns / 1ps

package ptf_pkg;

   // Pipeline depth: trig and frame paths meet at stage TRIG_LAT, results leave at LAT
   localparam int unsigned TRIG_LAT = 16;
   localparam int unsigned LAT      = 22;
   localparam int unsigned NQ       = 5;

   // 2*pi in Q30, and Q30 one
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1073741824;

   // Horner divisors, innermost first, and reciprocals scaled by 2^33
   localparam logic [63:0] SIN_DIV [4] = '{64'd72, 64'd42, 64'd20, 64'd6};
   localparam logic [63:0] COS_DIV [4] = '{64'd90, 64'd56, 64'd30, 64'd12};
   localparam logic [63:0] SIN_RCP [4] = '{64'd8589934592 / 64'd72,
                                          64'd8589934592 / 64'd42,
                                          64'd8589934592 / 64'd20,
                                          64'd8589934592 / 64'd6};
   localparam logic [63:0] COS_RCP [4] = '{64'd8589934592 / 64'd90,
                                          64'd8589934592 / 64'd56,
                                          64'd8589934592 / 64'd30,
                                          64'd8589934592 / 64'd12};

   // Scale factors in Q24
   localparam logic [24:0] K_SQRT2  = 25'd23726566;
   localparam logic [24:0] K_ISQRT2 = 25'd11863283;
   localparam logic [24:0] K_ISQRT6 = 25'd6849270;

   // Result saturation bounds
   localparam logic signed [63:0] RES_MAX = 64'sd8388607;
   localparam logic signed [63:0] RES_MIN = -64'sd8388608;

   // cos/sin in signed Q1.16
   typedef logic signed [17:0] trig_type;

   // Frame combination terms in Q5.30
   typedef logic signed [35:0] term_type;

   typedef struct packed {
      term_type a;
      term_type b;
   } ab_type;

   typedef logic signed [23:0] res_type;

endpackage

[rtl/core/ptf_quadrupole_factor_eval.sv]
// Throughput: one transaction per cycle unless a response stalls. A request passes
// through 22 registered stages: 16 form the cos/sin path (Horner terms of a two-stage
// constant divide, after a multiply on all but the first), 6 mix, scale and round.
// A stalled response holds every stage in place; nothing is dropped or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module ptf_quadrupole_factor_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_freq_term,
   input  logic [15:0]        req_phase,
   input  logic signed [15:0] req_e1_x,
   input  logic signed [15:0] req_e1_y,
   input  logic signed [15:0] req_e1_z,
   input  logic signed [15:0] req_e2_x,
   input  logic signed [15:0] req_e2_y,
   input  logic signed [15:0] req_e2_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_q0,
   output logic signed [23:0] rsp_q1,
   output logic signed [23:0] rsp_q2,
   output logic signed [23:0] rsp_q3,
   output logic signed [23:0] rsp_q4
);

   // Global advance: move whenever the last stage is empty or being taken
   logic en;
   logic [ptf_pkg::LAT:1] v_ff;
   logic [ptf_pkg::LAT:1] v_in;

   assign en        = !v_ff[ptf_pkg::LAT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v_ff[ptf_pkg::LAT];
   assign v_in      = {v_ff[ptf_pkg::LAT-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   ptf_pkg::trig_type                 cos_w;
   ptf_pkg::trig_type                 sin_w;
   ptf_pkg::ab_type [ptf_pkg::NQ-1:0] ab_w;
   ptf_pkg::res_type                  q_w [ptf_pkg::NQ];

   ptf_trig u_trig (
      .clock   (clock),
      .en      (en),
      .phase   (req_phase),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   ptf_frame u_frame (
      .clock  (clock),
      .en     (en),
      .e1_x   (req_e1_x),
      .e1_y   (req_e1_y),
      .e1_z   (req_e1_z),
      .e2_x   (req_e2_x),
      .e2_y   (req_e2_y),
      .e2_z   (req_e2_z),
      .ab_out (ab_w)
   );

   ptf_factor u_factor (
      .clock     (clock),
      .en        (en),
      .freq_term (req_freq_term),
      .cos_in    (cos_w),
      .sin_in    (sin_w),
      .ab_in     (ab_w),
      .q_out     (q_w)
   );

   assign rsp_q0 = q_w[0];
   assign rsp_q1 = q_w[1];
   assign rsp_q2 = q_w[2];
   assign rsp_q3 = q_w[3];
   assign rsp_q4 = q_w[4];

endmodule

[rtl/core/ptf_trig.sv]
// Pipelined cos/sin of the doubled phase via Horner series in Q30.
`timescale 1ns / 1ps

module ptf_trig (
   input  logic              clock,
   input  logic              en,
   input  logic [15:0]       phase,
   output ptf_pkg::trig_type cos_out,
   output ptf_pkg::trig_type sin_out
);

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Unsigned Q30 product with round half up
   function automatic logic [63:0] umul30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      begin
         p = {32'b0, a} * {32'b0, b};
         return (p + 64'd536870912) >> 30;
      end
   endfunction

   logic [15:0] ang;
   logic [63:0] x_prod;
   assign ang    = {phase[14:0], 1'b0};
   assign x_prod = {50'b0, ang[13:0]} * ptf_pkg::TWO_PI_Q30 + 64'd32768;

   // Side pipe for x, x^2 and quadrant
   logic [30:0] x_ff    [1:13];
   logic [31:0] x2_ff   [2:13];
   quad_type    quad_ff [1:15];
   logic [63:0] x2_full;
   assign x2_full = umul30({1'b0, x_ff[1]}, {1'b0, x_ff[1]});

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1]    <= x_prod[46:16];
         quad_ff[1] <= quad_type'(ang[15:14]);
         x2_ff[2]   <= x2_full[31:0];
      end
   end

   for (genvar gs = 2; gs <= 15; gs++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) quad_ff[gs] <= quad_ff[gs-1];
      end
      if (gs <= 13) begin : g_x
         always_ff @(posedge clock) begin
            if (en) x_ff[gs] <= x_ff[gs-1];
         end
      end
      if (gs >= 3 && gs <= 13) begin : g_x2
         always_ff @(posedge clock) begin
            if (en) x2_ff[gs] <= x2_ff[gs-1];
         end
      end
   end

   // Horner lanes: lane 0 sine, lane 1 cosine; each level is mul (from level 1 on), divide, divide-correct
   logic [31:0] m_ff    [2][1:3];
   logic [32:0] n_ff    [2][4];
   logic [63:0] prod_ff [2][4];
   logic [30:0] t_ff    [2][4];

   for (genvar gl = 0; gl < 2; gl++) begin : g_lane
      for (genvar gv = 0; gv < 4; gv++) begin : g_lvl
         localparam logic [63:0] DV  = (gl == 0) ? ptf_pkg::SIN_DIV[gv] : ptf_pkg::COS_DIV[gv];
         localparam logic [63:0] RCP = (gl == 0) ? ptf_pkg::SIN_RCP[gv] : ptf_pkg::COS_RCP[gv];

         logic [31:0] src;
         logic [32:0] nd;
         logic [63:0] rcp_prod;
         logic [30:0] q0;
         logic [63:0] rem;
         logic [63:0] q;
         logic [63:0] t_new;

         // Multiply stage feeding the divide; level 0 takes x^2 directly
         if (gv == 0) begin : g_first
            assign src = x2_ff[2];
         end else begin : g_mul
            logic [63:0] m_full;
            assign m_full = umul30(x2_ff[3*gv+1], {1'b0, t_ff[gl][gv-1]});
            always_ff @(posedge clock) begin
               if (en) m_ff[gl][gv] <= m_full[31:0];
            end
            assign src = m_ff[gl][gv];
         end

         // Divide by constant: reciprocal product, then one correction step
         assign nd       = {1'b0, src} + DV[32:0] / 33'd2;
         assign rcp_prod = {31'b0, nd} * RCP;
         assign q0       = prod_ff[gl][gv][63:33];
         assign rem      = {31'b0, n_ff[gl][gv]} - {33'b0, q0} * DV;
         assign q        = (rem >= DV) ? {33'b0, q0} + 64'd1 : {33'b0, q0};
         assign t_new    = (q >= ptf_pkg::ONE_Q30) ? 64'd0 : ptf_pkg::ONE_Q30 - q;

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[gl][gv]    <= nd;
               prod_ff[gl][gv] <= rcp_prod;
               t_ff[gl][gv]    <= t_new[30:0];
            end
         end
      end
   end

   // Final multiply of each series
   logic [30:0] s30_ff;
   logic [31:0] cm_ff;
   logic [63:0] s30_full;
   logic [63:0] cm_full;
   assign s30_full = umul30({1'b0, x_ff[13]}, {1'b0, t_ff[0][3]});
   assign cm_full  = umul30(x2_ff[13], {1'b0, t_ff[1][3]});

   always_ff @(posedge clock) begin
      if (en) begin
         s30_ff <= s30_full[30:0];
         cm_ff  <= cm_full[31:0];
      end
   end

   // Last cosine term, then round both to Q1.16
   logic [32:0] half;
   logic [32:0] c30;
   logic [32:0] c_rnd;
   logic [31:0] s_rnd;
   logic [17:0] s_ff;
   logic [17:0] c_ff;
   assign half  = ({1'b0, cm_ff} + 33'd1) >> 1;
   assign c30   = (half >= ptf_pkg::ONE_Q30[32:0]) ? 33'd0 : ptf_pkg::ONE_Q30[32:0] - half;
   assign c_rnd = (c30 + 33'd8192) >> 14;
   assign s_rnd = ({1'b0, s30_ff} + 32'd8192) >> 14;

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_rnd[17:0];
         c_ff <= c_rnd[17:0];
      end
   end

   // Quadrant mapping
   ptf_pkg::trig_type cos_ff;
   ptf_pkg::trig_type sin_ff;
   ptf_pkg::trig_type s_pos;
   ptf_pkg::trig_type c_pos;
   assign s_pos = ptf_pkg::trig_type'(s_ff);
   assign c_pos = ptf_pkg::trig_type'(c_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         case (quad_ff[15])
            QUAD_0: begin
               sin_ff <= s_pos;
               cos_ff <= c_pos;
            end
            QUAD_1: begin
               sin_ff <= c_pos;
               cos_ff <= -s_pos;
            end
            QUAD_2: begin
               sin_ff <= -s_pos;
               cos_ff <= -c_pos;
            end
            default: begin
               sin_ff <= -c_pos;
               cos_ff <= s_pos;
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

[rtl/core/ptf_frame.sv]
// Frame vector products and per-factor combination terms, delayed to meet the trig path.
`timescale 1ns / 1ps

module ptf_frame (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [15:0]                   e1_x,
   input  logic signed [15:0]                   e1_y,
   input  logic signed [15:0]                   e1_z,
   input  logic signed [15:0]                   e2_x,
   input  logic signed [15:0]                   e2_y,
   input  logic signed [15:0]                   e2_z,
   output ptf_pkg::ab_type [ptf_pkg::NQ-1:0]    ab_out
);

   function automatic ptf_pkg::term_type ext(input logic signed [31:0] p);
      return ptf_pkg::term_type'(p);
   endfunction

   // Stage 1: component products
   logic signed [31:0] axx_ff, ayy_ff, azz_ff, bxx_ff, byy_ff, bzz_ff;
   logic signed [31:0] axbx_ff, ayby_ff, azbz_ff, axay_ff, bxby_ff, axby_ff, aybx_ff;
   logic signed [31:0] axaz_ff, bxbz_ff, axbz_ff, azbx_ff, ayaz_ff, bybz_ff, aybz_ff, azby_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         axx_ff  <= 32'(e1_x) * 32'(e1_x);
         ayy_ff  <= 32'(e1_y) * 32'(e1_y);
         azz_ff  <= 32'(e1_z) * 32'(e1_z);
         bxx_ff  <= 32'(e2_x) * 32'(e2_x);
         byy_ff  <= 32'(e2_y) * 32'(e2_y);
         bzz_ff  <= 32'(e2_z) * 32'(e2_z);
         axbx_ff <= 32'(e1_x) * 32'(e2_x);
         ayby_ff <= 32'(e1_y) * 32'(e2_y);
         azbz_ff <= 32'(e1_z) * 32'(e2_z);
         axay_ff <= 32'(e1_x) * 32'(e1_y);
         bxby_ff <= 32'(e2_x) * 32'(e2_y);
         axby_ff <= 32'(e1_x) * 32'(e2_y);
         aybx_ff <= 32'(e1_y) * 32'(e2_x);
         axaz_ff <= 32'(e1_x) * 32'(e1_z);
         bxbz_ff <= 32'(e2_x) * 32'(e2_z);
         axbz_ff <= 32'(e1_x) * 32'(e2_z);
         azbx_ff <= 32'(e1_z) * 32'(e2_x);
         ayaz_ff <= 32'(e1_y) * 32'(e1_z);
         bybz_ff <= 32'(e2_y) * 32'(e2_z);
         aybz_ff <= 32'(e1_y) * 32'(e2_z);
         azby_ff <= 32'(e1_z) * 32'(e2_y);
      end
   end

   // Stage 2: A and B terms of each factor
   ptf_pkg::ab_type [ptf_pkg::NQ-1:0] ab_in;
   ptf_pkg::ab_type [ptf_pkg::NQ-1:0] ab_ff [2:ptf_pkg::TRIG_LAT];

   always_comb begin
      ab_in[0].a = ext(axx_ff) + ext(byy_ff) - ext(bxx_ff) - ext(ayy_ff);
      ab_in[0].b = (ext(axbx_ff) - ext(ayby_ff)) <<< 1;
      ab_in[1].a = ext(axay_ff) - ext(bxby_ff);
      ab_in[1].b = ext(axby_ff) + ext(aybx_ff);
      ab_in[2].a = ext(axaz_ff) - ext(bxbz_ff);
      ab_in[2].b = ext(axbz_ff) + ext(azbx_ff);
      ab_in[3].a = ext(ayaz_ff) - ext(bybz_ff);
      ab_in[3].b = ext(aybz_ff) + ext(azby_ff);
      ab_in[4].a = ((ext(bzz_ff) - ext(azz_ff)) <<< 1) + ext(axx_ff) + ext(ayy_ff)
                   - ext(bxx_ff) - ext(byy_ff);
      ab_in[4].b = (ext(axbx_ff) + ext(ayby_ff) - (ext(azbz_ff) <<< 1)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en) ab_ff[2] <= ab_in;
   end

   // Delay to the stage where cos/sin are ready
   for (genvar gs = 3; gs <= ptf_pkg::TRIG_LAT; gs++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) ab_ff[gs] <= ab_ff[gs-1];
      end
   end

   assign ab_out = ab_ff[ptf_pkg::TRIG_LAT];

endmodule

[rtl/core/ptf_factor.sv]
// Five factor lanes: trig mix, frequency scale and constant scale with rounding.
`timescale 1ns / 1ps

module ptf_factor (
   input  logic                              clock,
   input  logic                              en,
   input  logic [15:0]                       freq_term,
   input  ptf_pkg::trig_type                 cos_in,
   input  ptf_pkg::trig_type                 sin_in,
   input  ptf_pkg::ab_type [ptf_pkg::NQ-1:0] ab_in,
   output ptf_pkg::res_type                  q_out [ptf_pkg::NQ]
);

   // Signed right shift rounding half away from zero
   function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                               input int unsigned n);
      logic [63:0] mag;
      logic [63:0] rnd;
      begin
         mag = v[63] ? -v : v;
         rnd = (mag + (64'd1 << (n - 1))) >> n;
         return v[63] ? -rnd : rnd;
      end
   endfunction

   // Frequency term travels alongside until its multiply stage
   localparam int unsigned FDLY = ptf_pkg::TRIG_LAT + 2;
   logic [15:0] f_ff [1:FDLY];

   always_ff @(posedge clock) begin
      if (en) f_ff[1] <= freq_term;
   end

   for (genvar gs = 2; gs <= FDLY; gs++) begin : g_fdly
      always_ff @(posedge clock) begin
         if (en) f_ff[gs] <= f_ff[gs-1];
      end
   end

   for (genvar gi = 0; gi < ptf_pkg::NQ; gi++) begin : g_lane
      localparam logic [24:0] K = (gi == 0) ? ptf_pkg::K_ISQRT2 :
                                  (gi == 4) ? ptf_pkg::K_ISQRT6 : ptf_pkg::K_SQRT2;

      logic signed [53:0] ca_w;
      logic signed [53:0] sb_w;
      logic signed [51:0] ca_ff;
      logic signed [51:0] sb_ff;
      logic signed [63:0] p1_w;
      logic signed [37:0] p1_ff;
      logic signed [53:0] pf_w;
      logic signed [53:0] pf_ff;
      logic signed [63:0] p2_w;
      logic signed [38:0] p2_ff;
      logic signed [63:0] pk_ff;
      logic signed [63:0] p3_w;
      ptf_pkg::res_type   q_ff;

      // Trig mix
      assign ca_w = 54'(cos_in) * 54'(ab_in[gi].a);
      assign sb_w = 54'(sin_in) * 54'(ab_in[gi].b);
      assign p1_w = rshr(64'(ca_ff) + 64'(sb_ff), 16);
      // Frequency scale
      assign pf_w = 54'(p1_ff) * 54'($signed({1'b0, f_ff[FDLY]}));
      assign p2_w = rshr(64'(pf_ff), 15);
      // Constant scale, round to Q19
      assign p3_w = rshr(pk_ff, 35);

      always_ff @(posedge clock) begin
         if (en) begin
            ca_ff <= ca_w[51:0];
            sb_ff <= sb_w[51:0];
            p1_ff <= p1_w[37:0];
            pf_ff <= pf_w;
            p2_ff <= p2_w[38:0];
            pk_ff <= 64'(p2_ff) * 64'($signed({1'b0, K}));
            if (p3_w > ptf_pkg::RES_MAX) begin
               q_ff <= ptf_pkg::RES_MAX[23:0];
            end else if (p3_w < ptf_pkg::RES_MIN) begin
               q_ff <= ptf_pkg::RES_MIN[23:0];
            end else begin
               q_ff <= p3_w[23:0];
            end
         end
      end

      assign q_out[gi] = q_ff;
   end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the quadrupole projection factor evaluator.
`timescale 1ns / 1ps

module tb_top;

   localparam int N_RANDOM = 400;
   localparam int MAX_GAP  = 40;

   // One input sample and one set of five factors
   typedef struct packed {
      logic [15:0]        freq_term;
      logic [15:0]        phase;
      logic signed [15:0] e1_x, e1_y, e1_z, e2_x, e2_y, e2_z;
   } sample_type;

   typedef struct packed {
      logic signed [23:0] q0, q1, q2, q3, q4;
   } factors_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_freq_term = '0, req_phase = '0;
   logic signed [15:0] req_e1_x = '0, req_e1_y = '0, req_e1_z = '0;
   logic signed [15:0] req_e2_x = '0, req_e2_y = '0, req_e2_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [23:0] rsp_q0, rsp_q1, rsp_q2, rsp_q3, rsp_q4;

   sample_type  pending_samples[$];
   factors_type expected_factors[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          sample_count = 0;
   bit          stimulus_done = 1'b0;
   bit          hold_sender = 1'b0;
   bit          req_accepted = 1'b0;

   ptf_quadrupole_factor_eval u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Q30 multiply, round half up
   function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint unsigned div_round(longint unsigned a, longint unsigned d);
      return (a + d / 2) / d;
   endfunction

   function automatic longint unsigned sat_one_minus(longint unsigned t);
      return (t >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - t;
   endfunction

   // Signed shift right, rounding half away from zero
   function automatic longint round_shift(longint v, int n);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (n - 1))) >> n;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   // cos and sin of the doubled phase, signed Q1.16
   function automatic void doubled_angle_trig(input logic [15:0] phase, output longint co,
                                              output longint si);
      logic [15:0] ang;
      longint unsigned x, x2, t, s30, c30;
      longint s, c;
      ang = {phase[14:0], 1'b0};
      x   = (longint'(ang[13:0]) * 64'd6746518852 + 32768) >> 16;
      x2  = mul_q30(x, x);
      t   = sat_one_minus(div_round(x2, 72));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 42));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 20));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 6));
      s30 = mul_q30(x, t);
      t   = sat_one_minus(div_round(x2, 90));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 56));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 30));
      t   = sat_one_minus(div_round(mul_q30(x2, t), 12));
      c30 = sat_one_minus(div_round(mul_q30(x2, t), 2));
      s   = (s30 + (1 << 13)) >> 14;
      c   = (c30 + (1 << 13)) >> 14;
      case (ang[15:14])
         2'd0: begin si = s;  co = c;  end
         2'd1: begin si = c;  co = -s; end
         2'd2: begin si = -s; co = -c; end
         default: begin si = -c; co = s; end
      endcase
   endfunction

   function automatic logic signed [23:0] scaled_factor(longint c, longint s, longint a,
                                                        longint b, longint f, longint k);
      longint p;
      p = round_shift(c * a + s * b, 16);
      p = round_shift(p * f, 15);
      p = round_shift(p * k, 35);
      if (p > ptf_pkg::RES_MAX) p = ptf_pkg::RES_MAX;
      if (p < ptf_pkg::RES_MIN) p = ptf_pkg::RES_MIN;
      return p[23:0];
   endfunction

   function automatic factors_type quadrupole_factors(sample_type smp);
      factors_type r;
      longint c, s, f, ax, ay, az, bx, by, bz;
      doubled_angle_trig(smp.phase, c, s);
      f  = smp.freq_term;
      ax = smp.e1_x; ay = smp.e1_y; az = smp.e1_z;
      bx = smp.e2_x; by = smp.e2_y; bz = smp.e2_z;
      r.q0 = scaled_factor(c, s, ax*ax + by*by - bx*bx - ay*ay, 2*(ax*bx - ay*by), f,
                           ptf_pkg::K_ISQRT2);
      r.q1 = scaled_factor(c, s, ax*ay - bx*by, ax*by + ay*bx, f, ptf_pkg::K_SQRT2);
      r.q2 = scaled_factor(c, s, ax*az - bx*bz, ax*bz + az*bx, f, ptf_pkg::K_SQRT2);
      r.q3 = scaled_factor(c, s, ay*az - by*bz, ay*bz + az*by, f, ptf_pkg::K_SQRT2);
      r.q4 = scaled_factor(c, s, 2*bz*bz - 2*az*az + ax*ax + ay*ay - bx*bx - by*by,
                           2*(ax*bx + ay*by - 2*az*bz), f, ptf_pkg::K_ISQRT6);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, MAX_GAP);
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH result %0d: %s", result_count, what);
   endtask

   function automatic sample_type random_sample();
      sample_type smp;
      smp = {$urandom, $urandom, $urandom, $urandom};
      // Unit-ish frames keep factors in range; raw noise exercises saturation
      if ($urandom_range(0, 3) != 0) begin
         smp.e1_x = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
         smp.e1_y = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
         smp.e1_z = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
         smp.e2_x = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
         smp.e2_y = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
         smp.e2_z = $signed(16'($urandom_range(0, 46340))) - 16'sd23170;
      end
      return smp;
   endfunction

   // Driver: presents queued samples at the falling edge
   int send_gap = 0;
   int recv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_accepted) begin
            void'(pending_samples.pop_front());
            send_gap = random_gap();
         end
         if (!req_valid || req_accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0 && !hold_sender) begin
               req_valid     <= 1'b1;
               req_freq_term <= pending_samples[0].freq_term;
               req_phase     <= pending_samples[0].phase;
               req_e1_x      <= pending_samples[0].e1_x;
               req_e1_y      <= pending_samples[0].e1_y;
               req_e1_z      <= pending_samples[0].e1_z;
               req_e2_x      <= pending_samples[0].e2_x;
               req_e2_y      <= pending_samples[0].e2_y;
               req_e2_z      <= pending_samples[0].e2_z;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // Response side: ready bursts separated by random stalls
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 1) == 1) recv_gap = random_gap();
         end
      end
   end

   // Monitor: predicts on accepted requests, checks accepted responses
   always @(posedge clock) begin
      factors_type want;
      req_accepted = !reset && req_valid && req_ready;
      if (req_accepted) begin
         expected_factors.push_back(quadrupole_factors({req_freq_term, req_phase,
            req_e1_x, req_e1_y, req_e1_z, req_e2_x, req_e2_y, req_e2_z}));
         sample_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_factors.size() == 0) begin
            report_mismatch("unexpected response transaction");
         end else begin
            want = expected_factors.pop_front();
            if (rsp_q0 !== want.q0)
               report_mismatch($sformatf("q0 got %0d expected %0d", rsp_q0, want.q0));
            if (rsp_q1 !== want.q1)
               report_mismatch($sformatf("q1 got %0d expected %0d", rsp_q1, want.q1));
            if (rsp_q2 !== want.q2)
               report_mismatch($sformatf("q2 got %0d expected %0d", rsp_q2, want.q2));
            if (rsp_q3 !== want.q3)
               report_mismatch($sformatf("q3 got %0d expected %0d", rsp_q3, want.q3));
            if (rsp_q4 !== want.q4)
               report_mismatch($sformatf("q4 got %0d expected %0d", rsp_q4, want.q4));
         end
         result_count++;
      end
   end

   // Stimulus and end of run
   initial begin
      sample_type smp;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, phase quadrant edges, ideal and degenerate frames
      pending_samples.push_back('{16'hFFFF, 16'h0000, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0});
      pending_samples.push_back('{16'h8000, 16'h2000, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0});
      pending_samples.push_back('{16'h8000, 16'h4000, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF});
      pending_samples.push_back('{16'h8000, 16'h6000, 16'sh5A82, 0, 16'sh5A82, 0, 16'sh7FFF,
                                  0});
      pending_samples.push_back('{16'h0000, 16'h1234, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      pending_samples.push_back('{16'hFFFF, 16'hFFFF, -16'sd32768, -16'sd32768, -16'sd32768,
                                  -16'sd32768, -16'sd32768, -16'sd32768});
      pending_samples.push_back('{16'hFFFF, 16'h1FFF, 16'sh7FFF, -16'sd32768, 16'sh7FFF,
                                  -16'sd32768, 16'sh7FFF, -16'sd32768});
      pending_samples.push_back('{16'hFFFF, 16'h3FFF, -16'sd32768, 16'sh7FFF, -16'sd32768,
                                  16'sh7FFF, -16'sd32768, 16'sh7FFF});
      pending_samples.push_back('{16'h0001, 16'h8000, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1,
                                  -16'sd1});
      pending_samples.push_back('{16'hFFFF, 16'hC000, 0, 0, 0, 0, 0, 0});
      pending_samples.push_back('{16'hAAAA, 16'h5555, 16'sh5555, -16'sh5556, 16'sh2AAA,
                                  16'sh1555, 16'sh5555, -16'sh2AAA});
      pending_samples.push_back('{16'h5555, 16'hAAAA, -16'sh5556, 16'sh5555, -16'sh2AAB,
                                  -16'sh1556, -16'sh5556, 16'sh2AAA});

      // Random, with a pause that drains the pipeline halfway
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            wait (pending_samples.size() == 0);
            hold_sender = 1'b1;
            wait (expected_factors.size() == 0);
            @(negedge clock);
            hold_sender = 1'b0;
         end
         smp = random_sample();
         pending_samples.push_back(smp);
      end

      wait (pending_samples.size() == 0);
      stimulus_done = 1'b1;
      wait (expected_factors.size() == 0);
      repeat (ptf_pkg::LAT + 10) @(posedge clock);

      $display("Checked %0d samples and %0d responses, directed frames, quadrant edges",
               sample_count, result_count);
      $display("and random frames with saturation under random stalls on both sides.");
      if (mismatch_count == 0 && expected_factors.size() == 0) begin
         $display("ptf_quadrupole_factor_eval verification clean");
      end else begin
         $display("ptf_quadrupole_factor_eval verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("TIMEOUT with %0d responses outstanding", expected_factors.size());
      $display("ptf_quadrupole_factor_eval verification failed");
      $finish;
   end

endmodule

[ptf_quadrupole_factor_eval.f]
rtl/core/ptf_pkg.sv
rtl/core/ptf_trig.sv
rtl/core/ptf_frame.sv
rtl/core/ptf_factor.sv
rtl/core/ptf_quadrupole_factor_eval.sv
verif/tb_top.sv
